[rtl/core/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam logic [7:0]  LEAD2_MIN     = 8'hC0;
   localparam logic [7:0]  LEAD3_MIN     = 8'hE0;
   localparam logic [7:0]  LEAD4_MIN     = 8'hF0;
   localparam logic [7:0]  LEAD5_MIN     = 8'hF8;
   localparam logic [7:0]  LEAD6_MIN     = 8'hFC;
   localparam logic [5:0]  CONT_MASK     = 6'h3F;
   localparam logic [30:0] SURR_LOW      = 31'h0000_D800;
   localparam logic [30:0] SURR_HIGH     = 31'h0000_DFFF;
   localparam logic [30:0] BMP_MAX       = 31'h0000_FFFF;
   localparam logic [19:0] SUPP_BASE     = 20'h1_0000;
   localparam logic [15:0] HIGH_SURR_TAG = 16'hD800;
   localparam logic [15:0] LOW_SURR_TAG  = 16'hDC00;
   localparam logic [9:0]  HALF_MASK     = 10'h3FF;

   // Results that one byte produces, handed from the decoder to the output stage.
   typedef struct packed {
      logic        valid;
      logic        two;
      logic        eos;
      logic [15:0] unit0;
      logic [15:0] unit1;
   } dec_result_type;

endpackage

[rtl/core/utf8_to_utf16_transcoder_top.sv]
// Top level of the UTF-8 to UTF-16 transcoder: input register, decoder, output stage.
// Each byte passes from the input register through the combinational decoder into the
// output register, which takes the result only once its previous beats have been taken.
// Throughput: one byte per cycle while the receiver does not stall; a byte that completes
// a code point above 0xFFFF holds the single output register for two beats, one per surrogate half.
// Reset clears the sequence state and the valid flags of the input and output registers.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_top
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_utf16_unit,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_string
);

   logic           a_valid_ff, a_valid_in;
   logic [7:0]     a_byte_ff;
   logic [2:0]     pending_ff, pending_in;
   logic [30:0]    partial_ff, partial_in;
   logic           b_valid_ff, b_valid_in;
   logic           b_idx_ff, b_idx_in;
   dec_result_type b_res_ff;
   dec_result_type dec_res;

   logic req_take;
   logic a_move;
   logic b_pop;
   logic b_done;
   logic b_free;

   u8u16_decode u_decode (
      .in_byte    (a_byte_ff),
      .pending    (pending_ff),
      .partial    (partial_ff),
      .pending_in (pending_in),
      .partial_in (partial_in),
      .result     (dec_res)
   );

   assign b_pop  = b_valid_ff && !rsp_stall;
   assign b_done = b_pop && (!b_res_ff.two || b_idx_ff);
   assign b_free = !b_valid_ff || b_done;
   assign a_move = a_valid_ff && b_free;

   assign req_stall = a_valid_ff && !a_move;
   assign req_take  = req_valid && !req_stall;

   assign a_valid_in = req_take || (a_valid_ff && !a_move);

   always_comb begin
      b_valid_in = b_valid_ff;
      b_idx_in   = b_idx_ff;
      if (b_pop && !b_done) begin
         b_idx_in = 1'b1;
      end
      if (b_done) begin
         b_valid_in = 1'b0;
         b_idx_in   = 1'b0;
      end
      // A byte that yields nothing only advances the sequence state.
      if (a_move && dec_res.valid) begin
         b_valid_in = 1'b1;
         b_idx_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_idx_ff   <= 1'b0;
         pending_ff <= '0;
         partial_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         b_idx_ff   <= b_idx_in;
         if (a_move) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_byte_ff <= req_in_byte;
      end
      if (a_move && dec_res.valid) begin
         b_res_ff <= dec_res;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_utf16_unit    = b_idx_ff ? b_res_ff.unit1 : b_res_ff.unit0;
   assign rsp_last_of_run   = !b_res_ff.two || b_idx_ff;
   assign rsp_end_of_string = b_res_ff.eos && b_valid_ff;

   // The second surrogate half is only ever selected for a held pair.
   assert property (@(posedge clock) disable iff (reset)
      b_idx_ff |-> (b_valid_ff && b_res_ff.two))
      else $error("second half selected without a pending pair");

   // A terminator is a single unit of value zero.
   assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_res_ff.eos) |-> (!b_res_ff.two && rsp_utf16_unit == 16'd0))
      else $error("end of string beat carries data");

   // The first half of a pair is followed by its second half on the next beat.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_run) |=> (rsp_valid && b_idx_ff))
      else $error("low surrogate half lost");

   // The sequence state only moves when the input register hands a byte on.
   assert property (@(posedge clock) disable iff (reset)
      !a_move |=> ($stable(pending_ff) && $stable(partial_ff)))
      else $error("sequence state changed without a byte");

endmodule

[rtl/core/u8u16_decode.sv]
// Combinational byte decoder: next sequence state and the UTF-16 units it yields.
`timescale 1ns / 1ps

module u8u16_decode
   import u8u16_pkg::*;
(
   input  logic [7:0]     in_byte,
   input  logic [2:0]     pending,
   input  logic [30:0]    partial,
   output logic [2:0]     pending_in,
   output logic [30:0]    partial_in,
   output dec_result_type result
);

   logic        finish;
   logic [30:0] code;
   logic [30:0] shifted;
   logic [2:0]  count_dn;
   logic [19:0] offset;

   assign shifted  = {partial[24:0], in_byte[5:0] & CONT_MASK};
   assign count_dn = 3'(pending - 3'd1);
   assign offset   = 20'(code[19:0] - SUPP_BASE);

   always_comb begin
      pending_in = pending;
      partial_in = partial;
      finish     = 1'b0;
      code       = '0;
      if (pending == 3'd0) begin
         if (in_byte < LEAD2_MIN) begin
            finish = 1'b1;
            code   = {23'd0, in_byte};
         end else if (in_byte < LEAD3_MIN) begin
            partial_in = {26'd0, in_byte[4:0]};
            pending_in = 3'd1;
         end else if (in_byte < LEAD4_MIN) begin
            partial_in = {27'd0, in_byte[3:0]};
            pending_in = 3'd2;
         end else if (in_byte < LEAD5_MIN) begin
            partial_in = {28'd0, in_byte[2:0]};
            pending_in = 3'd3;
         end else if (in_byte < LEAD6_MIN) begin
            partial_in = {29'd0, in_byte[1:0]};
            pending_in = 3'd4;
         end else begin
            partial_in = {30'd0, in_byte[0]};
            pending_in = 3'd5;
         end
      end else begin
         pending_in = count_dn;
         if (count_dn != 3'd0) begin
            partial_in = shifted;
         end else begin
            partial_in = '0;
            finish     = 1'b1;
            code       = shifted;
         end
      end
   end

   always_comb begin
      result = '0;
      if (finish) begin
         if (code == 31'd0) begin
            result.valid = 1'b1;
            result.eos   = 1'b1;
         end else if (code >= SURR_LOW && code <= SURR_HIGH) begin
            result.valid = 1'b0;
         end else if (code > BMP_MAX) begin
            // Each half keeps ten bits, so code points past the last plane wrap.
            result.valid = 1'b1;
            result.two   = 1'b1;
            result.unit0 = HIGH_SURR_TAG | {6'd0, offset[19:10] & HALF_MASK};
            result.unit1 = LOW_SURR_TAG | {6'd0, offset[9:0] & HALF_MASK};
         end else begin
            result.valid = 1'b1;
            result.unit0 = code[15:0];
         end
      end
   end

endmodule

[tb/sv/utf8_to_utf16_checker.sv]
// Checker that predicts the UTF-16 result beats from accepted UTF-8 bytes and compares them.
`timescale 1ns / 1ps

module utf8_to_utf16_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_utf16_unit,
   input  logic        rsp_last_of_run,
   input  logic        rsp_end_of_string,
   output int          mismatch_count,
   output int          units_awaited
);

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_of_run;
      logic        end_of_string;
   } utf16_beat_type;

   utf16_beat_type awaited_beats[$];
   utf16_beat_type want;
   logic [2:0]     cont_left;
   logic [30:0]    code_acc;
   int             beat_num;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: result beat %0d: %s", $time, beat_num, msg);
      mismatch_count++;
   endtask

   // Appends one predicted beat at the tail of the queue.
   task automatic queue_beat(input utf16_beat_type beat);
      awaited_beats.insert(awaited_beats.size(), beat);
   endtask

   // Turns one finished code point into the UTF-16 beats it should produce.
   task automatic emit_code_point(input logic [30:0] cp);
      logic [19:0] offset;
      offset = cp[19:0] - 20'h1_0000;
      if (cp == '0) begin
         queue_beat({16'h0000, 1'b1, 1'b1});
      end else if (cp >= 31'h0000_D800 && cp <= 31'h0000_DFFF) begin
         // Lone surrogate code points are dropped without a beat.
      end else if (cp > 31'h0000_FFFF) begin
         // Each half keeps only ten bits, even past the Unicode range.
         queue_beat({16'hD800 | {6'b0, offset[19:10]}, 1'b0, 1'b0});
         queue_beat({16'hDC00 | {6'b0, offset[9:0]}, 1'b1, 1'b0});
      end else begin
         queue_beat({cp[15:0], 1'b1, 1'b0});
      end
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      if (cont_left == 3'd0) begin
         if (b < 8'hC0) begin
            emit_code_point({23'b0, b});
         end else if (b < 8'hE0) begin
            code_acc  = {26'b0, b[4:0]};
            cont_left = 3'd1;
         end else if (b < 8'hF0) begin
            code_acc  = {27'b0, b[3:0]};
            cont_left = 3'd2;
         end else if (b < 8'hF8) begin
            code_acc  = {28'b0, b[2:0]};
            cont_left = 3'd3;
         end else if (b < 8'hFC) begin
            code_acc  = {29'b0, b[1:0]};
            cont_left = 3'd4;
         end else begin
            code_acc  = {30'b0, b[0]};
            cont_left = 3'd5;
         end
      end else begin
         // Continuation bytes are not checked; only their low six bits count.
         code_acc  = {code_acc[24:0], b[5:0]};
         cont_left = cont_left - 3'd1;
         if (cont_left == 3'd0) begin
            emit_code_point(code_acc);
            code_acc = '0;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cont_left = '0;
         code_acc  = '0;
         awaited_beats.delete();
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_in_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, unit %h", rsp_utf16_unit));
            end else begin
               want = awaited_beats.pop_front();
               if (rsp_utf16_unit !== want.code_unit)
                  report_mismatch($sformatf("utf16_unit got %h, want %h",
                                            rsp_utf16_unit, want.code_unit));
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run got %b, want %b",
                                            rsp_last_of_run, want.last_of_run));
               if (rsp_end_of_string !== want.end_of_string)
                  report_mismatch($sformatf("end_of_string got %b, want %b",
                                            rsp_end_of_string, want.end_of_string));
            end
            beat_num++;
         end
      end
      units_awaited = awaited_beats.size();
   end

endmodule

[tb/sv/utf8_to_utf16_transcoder_top_tb.sv]
// Testbench top for the UTF-8 to UTF-16 transcoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_top_tb;

   localparam int CLK_PERIOD   = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 1800;
   localparam int NUM_DIRECTED = 25;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_utf16_unit;
   logic        rsp_last_of_run;
   logic        rsp_end_of_string;

   int mismatch_count;
   int units_awaited;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_off_left;
   int bytes_sent;
   int cycle_count;

   // Edge cases: terminator, ASCII top, a stray continuation, overlong zero, surrogate,
   // BMP top, first supplementary point, beyond the Unicode range, and a 0xFF lead.
   logic [7:0] directed_bytes [NUM_DIRECTED] = '{
      8'h00, 8'h7F, 8'h80,
      8'hC0, 8'h80,
      8'hED, 8'hA0, 8'h80,
      8'hEF, 8'hBF, 8'hBF,
      8'hF0, 8'h90, 8'h80, 8'h80,
      8'hF7, 8'hBF, 8'hBF, 8'hBF,
      8'hFF, 8'hBF, 8'h80, 8'hBF, 8'h80, 8'hBF
   };

   utf8_to_utf16_transcoder_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_utf16_unit    (rsp_utf16_unit),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_string (rsp_end_of_string)
   );

   utf8_to_utf16_checker result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_utf16_unit    (rsp_utf16_unit),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_string (rsp_end_of_string),
      .mismatch_count    (mismatch_count),
      .units_awaited     (units_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: a long hold-off counts down here, otherwise it stalls at random.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Mostly well-formed characters with random payload, plus terminators and noise bytes.
   task automatic send_random_char();
      int         pick;
      int         seq_len;
      logic [7:0] lead;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_byte(8'h00);
         return;
      end
      if (pick < 16) begin
         send_byte(8'($urandom_range(255)));
         return;
      end
      pick    = $urandom_range(99);
      seq_len = (pick < 25) ? 1 : (pick < 45) ? 2 : (pick < 70) ? 3 :
                (pick < 90) ? 4 : (pick < 95) ? 5 : 6;
      case (seq_len)
         1: begin
            lead = 8'($urandom_range(1, 127));
         end
         2: begin
            lead = 8'hC0 | 8'($urandom_range(31));
         end
         3: begin
            // Lead 0xED lands in the surrogate range about half the time.
            lead = ($urandom_range(4) == 0) ? 8'hED : (8'hE0 | 8'($urandom_range(15)));
         end
         4: begin
            lead = 8'hF0 | 8'($urandom_range(7));
         end
         5: begin
            lead = 8'hF8 | 8'($urandom_range(3));
         end
         default: begin
            lead = 8'hFC | 8'($urandom_range(3));
         end
      endcase
      send_byte(lead);
      for (int i = 1; i < seq_len; i++) begin
         send_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                            : (8'h80 | 8'($urandom_range(63))));
      end
   endtask

   // The count is first read after the next clock edge, so that it already includes the last byte.
   task automatic wait_for_drain();
      do begin
         @(posedge clock);
      end while (units_awaited != 0);
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_in_byte        = 8'h00;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_left      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) begin
         send_byte(directed_bytes[i]);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
               // The receiver holds off while bytes keep coming, so the block backs up.
               hold_off_left      = 300;
            end
            1: begin
               sender_idle_pct    = 79;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 79;
            end
            default: begin
               sender_idle_pct    = 13;
               receiver_stall_pct = 13;
            end
         endcase
         while (bytes_sent < NUM_DIRECTED + (phase + 1) * RANDOM_BYTES / 4) begin
            send_random_char();
         end
         if (phase == 1) begin
            req_valid <= 1'b0;
            wait_for_drain();
         end
      end

      req_valid <= 1'b0;
      receiver_stall_pct = 0;
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && units_awaited == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_decode.sv
rtl/core/utf8_to_utf16_transcoder_top.sv
tb/sv/utf8_to_utf16_checker.sv
tb/sv/utf8_to_utf16_transcoder_top_tb.sv
